>>> src/jst_pkg.sv
// Shared types, codes and literal tables for the JSON structure tokenizer.
`default_nettype none
package jst_pkg;

  typedef enum logic [3:0] {
    PH_VALUE,
    PH_WAITKEY,
    PH_KEY,
    PH_COLON,
    PH_STRING,
    PH_NUMBER,
    PH_LITERAL,
    PH_AFTER,
    PH_DONE
  } phase_t;

  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_OBJ_OPEN  = 4'd1;
  localparam logic [3:0] EV_ARR_OPEN  = 4'd2;
  localparam logic [3:0] EV_CLOSE     = 4'd3;
  localparam logic [3:0] EV_KEY_START = 4'd4;
  localparam logic [3:0] EV_KEY_BYTE  = 4'd5;
  localparam logic [3:0] EV_KEY_END   = 4'd6;
  localparam logic [3:0] EV_STR_START = 4'd7;
  localparam logic [3:0] EV_STR_BYTE  = 4'd8;
  localparam logic [3:0] EV_STR_END   = 4'd9;
  localparam logic [3:0] EV_NUMBER    = 4'd10;
  localparam logic [3:0] EV_TRUE      = 4'd11;
  localparam logic [3:0] EV_ERROR     = 4'd14;
  localparam logic [3:0] EV_DONE      = 4'd15;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_BAD_VALUE = 4'd1;
  localparam logic [3:0] ERR_KEY_QUOTE = 4'd2;
  localparam logic [3:0] ERR_COLON     = 4'd3;
  localparam logic [3:0] ERR_MISMATCH  = 4'd4;
  localparam logic [3:0] ERR_EARLY_END = 4'd5;
  localparam logic [3:0] ERR_KEY_LONG  = 4'd6;
  localparam logic [3:0] ERR_TOO_MANY  = 4'd7;
  localparam logic [3:0] ERR_TOO_DEEP  = 4'd8;
  localparam logic [3:0] ERR_LITERAL   = 4'd9;
  localparam logic [3:0] ERR_JUNK      = 4'd10;

  localparam logic [1:0] CFG_MAX_KEY    = 2'd0;
  localparam logic [1:0] CFG_MAX_VALUES = 2'd1;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic       number_closed;
    logic [4:0] nesting_depth;
    logic [7:0] element_index;
    logic [3:0] error_code;
    logic       document_done;
  } out_item_t;

  // classified byte as it sits in the queue
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
    logic       space;
    logic       digit;
    logic       num_cont;
  } cls_item_t;

  function automatic logic [2:0] lit_len(input logic [1:0] sel);
    case (sel)
      LIT_TRUE:  lit_len = 3'd4;
      LIT_FALSE: lit_len = 3'd5;
      LIT_NULL:  lit_len = 3'd4;
      default:   lit_len = 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
    case ({sel, pos})
      {LIT_TRUE, 3'd1}:  lit_char = "r";
      {LIT_TRUE, 3'd2}:  lit_char = "u";
      {LIT_TRUE, 3'd3}:  lit_char = "e";
      {LIT_FALSE, 3'd1}: lit_char = "a";
      {LIT_FALSE, 3'd2}: lit_char = "l";
      {LIT_FALSE, 3'd3}: lit_char = "s";
      {LIT_FALSE, 3'd4}: lit_char = "e";
      {LIT_NULL, 3'd1}:  lit_char = "u";
      {LIT_NULL, 3'd2}:  lit_char = "l";
      {LIT_NULL, 3'd3}:  lit_char = "l";
      default:           lit_char = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> src/jst_front.sv
// Front end: takes input bytes, classifies them and queues them for the parser.
`default_nettype none
module jst_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire jst_pkg::in_item_t in_data,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output jst_pkg::cls_item_t     q_item
);

  jst_pkg::cls_item_t cls;
  jst_pkg::cls_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  logic [7:0] b;

  assign b = in_data.text_byte;

  always_comb begin
    cls.text_byte   = b;
    cls.end_of_text = in_data.end_of_text;
    cls.space       = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    cls.digit       = (b >= "0") && (b <= "9");
    cls.num_cont    = cls.digit || (b == ".") || (b == "e") || (b == "E") ||
                      (b == "+") || (b == "-");
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> src/jst_back.sv
// Back end: parse state, container stack, config registers and result register.
`default_nettype none
module jst_back #(
  parameter int MAX_DEPTH  = 16,
  parameter int MAX_VALUES = 256,
  parameter int MAX_KEY    = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire jst_pkg::cls_item_t q_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [8:0]         cfg_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output jst_pkg::out_item_t      out_data
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int CW = $clog2(MAX_VALUES + 1);
  localparam int KW = $clog2(MAX_KEY);
  localparam int VW = (CW > 9) ? CW : 9;
  // stack holds the levels below the innermost one
  localparam int SD = (MAX_DEPTH > 1) ? MAX_DEPTH - 1 : 1;
  localparam int SW = (SD > 1) ? $clog2(SD) : 1;

  jst_pkg::phase_t phase, phase_next;
  logic [DW-1:0] depth, depth_next;
  logic          cur_mode, cur_mode_next;
  logic [CW-1:0] cur_count, cur_count_next;
  logic [1:0]    lit_sel, lit_sel_next;
  logic [2:0]    lit_pos, lit_pos_next;
  logic [KW-1:0] key_cnt, key_cnt_next;
  logic          bslash, bslash_next;
  logic [3:0]    sticky, sticky_next;
  logic [5:0]    cfg_key;
  logic [8:0]    cfg_vals;

  logic          stk_mode [SD];
  logic [CW-1:0] stk_cnt  [SD];
  logic          stk_we;
  logic [SW-1:0] stk_wa;
  logic [SW-1:0] stk_ra;
  logic          stk_wmode;
  logic [CW-1:0] stk_wcnt;

  jst_pkg::out_item_t res;
  logic          adv;

  jst_pkg::phase_t ph;
  logic [7:0]    b;
  logic          is_open, is_close, is_obj_b, starts, top_arr, cnt_full, do_close;
  logic [3:0]    ev, err;
  logic          nclosed;
  logic [8:0]    kl;
  logic [VW-1:0] lim;

  assign cfg_ready = 1'b1;
  assign q_ready   = !out_valid || out_ready;
  assign adv       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_key  <= 6'd63;
      cfg_vals <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        jst_pkg::CFG_MAX_KEY:    cfg_key  <= cfg_data[5:0];
        jst_pkg::CFG_MAX_VALUES: cfg_vals <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_key == 6'd0) kl = 9'd1;
    else if ({3'b0, cfg_key} > 9'(MAX_KEY - 1)) kl = 9'(MAX_KEY - 1);
    else kl = {3'b0, cfg_key};
    if (cfg_vals == 9'd0) lim = VW'(1);
    else if (VW'(cfg_vals) > VW'(MAX_VALUES)) lim = VW'(MAX_VALUES);
    else lim = VW'(cfg_vals);
  end

  assign b        = q_item.text_byte;
  assign is_open  = (b == "{") || (b == "[");
  assign is_close = (b == "}") || (b == "]");
  assign is_obj_b = (b == "{") || (b == "}");
  assign starts   = (b == 8'h22) || q_item.digit || (b == "-") || (b == "t") ||
                    (b == "f") || (b == "n");
  assign top_arr  = (depth != '0) && !cur_mode;
  assign cnt_full = (depth != '0) && (VW'(cur_count) >= lim);
  assign stk_ra   = SW'(depth - DW'(2));

  always_comb begin
    phase_next     = phase;
    depth_next     = depth;
    cur_mode_next  = cur_mode;
    cur_count_next = cur_count;
    lit_sel_next   = lit_sel;
    lit_pos_next   = lit_pos;
    key_cnt_next   = key_cnt;
    bslash_next    = bslash;
    sticky_next    = sticky;
    stk_we         = 1'b0;
    stk_wa         = SW'(depth - DW'(1));
    stk_wmode      = cur_mode;
    stk_wcnt       = cur_count;
    ev             = jst_pkg::EV_NONE;
    err            = jst_pkg::ERR_NONE;
    nclosed        = 1'b0;
    do_close       = 1'b0;
    ph             = phase;
    if (sticky == jst_pkg::ERR_NONE) begin
      if (phase == jst_pkg::PH_NUMBER) begin
        if (q_item.num_cont) begin
          ev = jst_pkg::EV_NUMBER;
        end else begin
          nclosed = 1'b1;
          ph = (depth == '0) ? jst_pkg::PH_DONE : jst_pkg::PH_AFTER;
        end
      end
      phase_next = ph;
      case (ph)
        jst_pkg::PH_VALUE: begin
          if (!q_item.space) begin
            if (is_close) begin
              if (top_arr && cur_count == '0) do_close = 1'b1;
              else err = jst_pkg::ERR_BAD_VALUE;
            end else if (is_open) begin
              if (depth >= DW'(MAX_DEPTH)) err = jst_pkg::ERR_TOO_DEEP;
              else if (top_arr && cnt_full) err = jst_pkg::ERR_TOO_MANY;
              else begin
                stk_we         = (depth != '0);
                stk_wcnt       = top_arr ? cur_count + CW'(1) : cur_count;
                cur_mode_next  = is_obj_b;
                cur_count_next = '0;
                depth_next     = depth + DW'(1);
                phase_next     = is_obj_b ? jst_pkg::PH_WAITKEY : jst_pkg::PH_VALUE;
                ev             = is_obj_b ? jst_pkg::EV_OBJ_OPEN : jst_pkg::EV_ARR_OPEN;
              end
            end else if (starts) begin
              if (top_arr && cnt_full) err = jst_pkg::ERR_TOO_MANY;
              else begin
                if (top_arr) cur_count_next = cur_count + CW'(1);
                if (b == 8'h22) begin
                  phase_next  = jst_pkg::PH_STRING;
                  bslash_next = 1'b0;
                  ev          = jst_pkg::EV_STR_START;
                end else if (q_item.digit || b == "-") begin
                  phase_next = jst_pkg::PH_NUMBER;
                  ev         = jst_pkg::EV_NUMBER;
                end else begin
                  lit_sel_next = (b == "t") ? jst_pkg::LIT_TRUE :
                                 (b == "f") ? jst_pkg::LIT_FALSE : jst_pkg::LIT_NULL;
                  lit_pos_next = 3'd1;
                  phase_next   = jst_pkg::PH_LITERAL;
                end
              end
            end else begin
              err = jst_pkg::ERR_BAD_VALUE;
            end
          end
        end
        jst_pkg::PH_WAITKEY: begin
          if (!q_item.space) begin
            if (b == 8'h22) begin
              if (cnt_full) err = jst_pkg::ERR_TOO_MANY;
              else begin
                if (depth != '0) cur_count_next = cur_count + CW'(1);
                phase_next   = jst_pkg::PH_KEY;
                key_cnt_next = '0;
                bslash_next  = 1'b0;
                ev           = jst_pkg::EV_KEY_START;
              end
            end else if (is_close && depth != '0 && cur_count == '0) begin
              do_close = 1'b1;
            end else begin
              err = jst_pkg::ERR_KEY_QUOTE;
            end
          end
        end
        jst_pkg::PH_KEY: begin
          if (b == 8'h22 && !bslash) begin
            phase_next = jst_pkg::PH_COLON;
            ev         = jst_pkg::EV_KEY_END;
          end else if (9'(key_cnt) >= kl) begin
            err = jst_pkg::ERR_KEY_LONG;
          end else begin
            key_cnt_next = key_cnt + KW'(1);
            bslash_next  = (b == 8'h5C) && !bslash;
            ev           = jst_pkg::EV_KEY_BYTE;
          end
        end
        jst_pkg::PH_COLON: begin
          if (!q_item.space) begin
            if (b == ":") phase_next = jst_pkg::PH_VALUE;
            else err = jst_pkg::ERR_COLON;
          end
        end
        jst_pkg::PH_STRING: begin
          if (b == 8'h22 && !bslash) begin
            ev         = jst_pkg::EV_STR_END;
            phase_next = (depth == '0) ? jst_pkg::PH_DONE : jst_pkg::PH_AFTER;
          end else begin
            bslash_next = (b == 8'h5C) && !bslash;
            ev          = jst_pkg::EV_STR_BYTE;
          end
        end
        jst_pkg::PH_LITERAL: begin
          if (lit_pos < jst_pkg::lit_len(lit_sel) && b == jst_pkg::lit_char(lit_sel, lit_pos))
          begin
            lit_pos_next = lit_pos + 3'd1;
            if (lit_pos_next == jst_pkg::lit_len(lit_sel)) begin
              ev         = jst_pkg::EV_TRUE + {2'b0, lit_sel};
              phase_next = (depth == '0) ? jst_pkg::PH_DONE : jst_pkg::PH_AFTER;
            end
          end else begin
            err = jst_pkg::ERR_LITERAL;
          end
        end
        jst_pkg::PH_AFTER: begin
          if (!q_item.space) begin
            if (b == ",") phase_next = top_arr ? jst_pkg::PH_VALUE : jst_pkg::PH_WAITKEY;
            else if (is_close) do_close = 1'b1;
            else err = jst_pkg::ERR_JUNK;
          end
        end
        jst_pkg::PH_DONE: begin
          if (q_item.space) ev = jst_pkg::EV_DONE;
          else err = jst_pkg::ERR_JUNK;
        end
        default: ;
      endcase
      if (do_close) begin
        if (depth == '0) err = jst_pkg::ERR_BAD_VALUE;
        else if (cur_mode != is_obj_b) err = jst_pkg::ERR_MISMATCH;
        else begin
          depth_next     = depth - DW'(1);
          cur_mode_next  = stk_mode[stk_ra];
          cur_count_next = stk_cnt[stk_ra];
          ev             = jst_pkg::EV_CLOSE;
          phase_next     = (depth_next == '0) ? jst_pkg::PH_DONE : jst_pkg::PH_AFTER;
        end
      end
      if (err == jst_pkg::ERR_NONE && q_item.end_of_text) begin
        if (phase_next == jst_pkg::PH_NUMBER && depth_next == '0)
          phase_next = jst_pkg::PH_DONE;
        else if (phase_next != jst_pkg::PH_DONE)
          err = jst_pkg::ERR_EARLY_END;
      end
      if (err != jst_pkg::ERR_NONE) sticky_next = err;
    end

    res.event_res     = (sticky_next != jst_pkg::ERR_NONE) ? jst_pkg::EV_ERROR : ev;
    res.number_closed = nclosed;
    res.nesting_depth = 5'(depth_next);
    res.element_index = (depth_next != '0 && cur_count_next != '0) ?
                        8'(cur_count_next - CW'(1)) : 8'd0;
    res.error_code    = sticky_next;
    res.document_done = (phase_next == jst_pkg::PH_DONE) && (sticky_next == jst_pkg::ERR_NONE);
  end

  always_ff @(posedge clk) begin
    if (adv && stk_we) begin
      stk_mode[stk_wa] <= stk_wmode;
      stk_cnt[stk_wa]  <= stk_wcnt;
    end
    if (adv) begin
      out_data  <= res;
      cur_mode  <= cur_mode_next;
      cur_count <= cur_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= jst_pkg::PH_VALUE;
      depth     <= '0;
      lit_sel   <= 2'd0;
      lit_pos   <= 3'd0;
      key_cnt   <= '0;
      bslash    <= 1'b0;
      sticky    <= jst_pkg::ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        phase   <= phase_next;
        depth   <= depth_next;
        lit_sel <= lit_sel_next;
        lit_pos <= lit_pos_next;
        key_cnt <= key_cnt_next;
        bslash  <= bslash_next;
        sticky  <= sticky_next;
      end
      if (adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_sticky_holds: assert property (@(posedge clk) disable iff (rst)
    (sticky != jst_pkg::ERR_NONE) |=> (sticky == $past(sticky)))
    else $error("sticky error changed");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(MAX_DEPTH))
    else $error("depth beyond limit");

  a_err_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error_code != jst_pkg::ERR_NONE) |->
    (out_data.event_res == jst_pkg::EV_ERROR))
    else $error("error result without error event");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.document_done) |-> (out_data.error_code == jst_pkg::ERR_NONE))
    else $error("done flagged with error");

  a_done_depth: assert property (@(posedge clk) disable iff (rst)
    (phase == jst_pkg::PH_DONE) |-> (depth == '0))
    else $error("document done inside a container");

endmodule
`default_nettype wire

>>> src/json_structure_tokenizer_core.sv
// JSON structure tokenizer: every input byte yields one token result.
// Channels (valid/ready, accepted when both are high at a rising clk edge):
//   in   : in_data {text_byte, end_of_text}, one byte of JSON text.
//   out  : out_data {event_res, number_closed, nesting_depth, element_index,
//          error_code, document_done}, exactly one result per input byte.
//   cfg  : cfg_index 0 = max_key_length (cfg_data[5:0]),
//          cfg_index 1 = max_values_per_container (cfg_data[8:0]);
//          cfg_ready is always high. Write only while the block is idle.
// An accepted byte passes through a queue slot and then the result register
// before its result is offered on out_data.
// Throughput: one byte per cycle while out_ready is high; the parser updates
// its state and the top of the container stack once per byte.
// A two-entry queue sits between the byte classifier and the parser, and the
// result register lets the next byte be taken while a waiting result is taken.
// When out_ready is low the result holds, the parser stops, the queue fills
// and in_ready drops once both queue slots are taken.
// Reset (rst, synchronous): parse state, depth, sticky error, queue and
// result valid clear; config registers return to 63 and 256. No clearing
// pass; the container stack is written as each level opens.
`default_nettype none
module json_structure_tokenizer_core #(
  parameter int MAX_DEPTH  = 16,
  parameter int MAX_VALUES = 256,
  parameter int MAX_KEY    = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire jst_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output jst_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [8:0]         cfg_data
);

  logic               q_valid;
  logic               q_ready;
  jst_pkg::cls_item_t q_item;

  jst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  jst_back #(
    .MAX_DEPTH  (MAX_DEPTH),
    .MAX_VALUES (MAX_VALUES),
    .MAX_KEY    (MAX_KEY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
